// ===== hdl/smfa_pkg.sv =====
`default_nettype none
package smfa_pkg;

  localparam int unsigned GRID_SIDE   = 16;
  localparam int unsigned CELL_W      = 8;
  localparam int unsigned CELL_COUNT  = GRID_SIDE * GRID_SIDE;
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned WORD_W      = WORD_BYTES * CELL_W;
  localparam int unsigned WORD_COUNT  = CELL_COUNT / WORD_BYTES;
  localparam int unsigned WORD_IDX_W  = $clog2(WORD_COUNT);
  localparam int unsigned BYTE_SEL_W  = $clog2(WORD_BYTES);
  localparam int unsigned NIBBLE_W    = 4;
  localparam int unsigned FRAME_LEN_W = 10;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef logic [CELL_W-1:0]     cell_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [WORD_IDX_W-1:0] word_idx_t;
  typedef logic [NIBBLE_W-1:0]   nibble_t;
  typedef logic [FRAME_LEN_W-1:0] frame_len_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_MAP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_MAP_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd2;

  localparam logic [CFG_DATA_W-1:0] ROW_MAP_LOW_RST  = 32'h048C_EA62;
  localparam logic [CFG_DATA_W-1:0] ROW_MAP_HIGH_RST = 32'hFDB9_1357;
  localparam frame_len_t            FRAME_LEN_RST    = 10'd288;

  // Look up the remapped row for a raw row nibble.
  function automatic nibble_t map_row(input nibble_t raw,
                                      input logic [CFG_DATA_W-1:0] map_lo,
                                      input logic [CFG_DATA_W-1:0] map_hi);
    logic [CFG_DATA_W-1:0] sel;
    sel = raw[3] ? map_hi : map_lo;
    return sel[{raw[2:0], 2'b00} +: NIBBLE_W];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/smfa_in_if.sv =====
`default_nettype none
interface smfa_in_if;
  logic                 valid;
  logic                 ready;
  smfa_pkg::cell_t      rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/smfa_out_if.sv =====
`default_nettype none
interface smfa_out_if;
  logic                  valid;
  logic                  ready;
  smfa_pkg::word_idx_t   word_index;
  smfa_pkg::cell_t       cell0;
  smfa_pkg::cell_t       cell1;
  smfa_pkg::cell_t       cell2;
  smfa_pkg::cell_t       cell3;
  smfa_pkg::cell_t       cell4;
  smfa_pkg::cell_t       cell5;
  smfa_pkg::cell_t       cell6;
  smfa_pkg::cell_t       cell7;
  logic                  last_word;

  modport source (output valid, output word_index, output cell0, output cell1,
                  output cell2, output cell3, output cell4, output cell5,
                  output cell6, output cell7, output last_word, input ready);
  modport sink   (input valid, input word_index, input cell0, input cell1,
                  input cell2, input cell3, input cell4, input cell5,
                  input cell6, input cell7, input last_word, output ready);
endinterface
`default_nettype wire

// ===== hdl/smfa_ram.sv =====
`default_nettype none
module smfa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/sensor_matrix_frame_assembler_unit.sv =====
`default_nettype none
// Channel   Dir  Payload                                   Transfer
// in_chan   in   rx_byte (header / value, alternating)     valid & ready
// out_chan  out  word_index, cell0..cell7, last_word       valid & ready
// cfg_*     in   cfg_index, cfg_wr_data                    cfg_wr_en
//
// A header byte is taken in idle; a value byte reads its grid word, then merges it
// and writes it back through the simple dual-port 32 x 64 grid RAM.
// A frame-ending value byte is followed by a dump of 32 words, each a RAM read
// and then an output load, the read held while out_chan.ready is low.
// Reset clears control and the 32 word valid bits; an unwritten word reads
// as zero, so no clearing pass is needed.
module sensor_matrix_frame_assembler_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  smfa_in_if.sink                                in_chan,
  smfa_out_if.source                             out_chan,
  input  wire logic                              cfg_wr_en,
  input  wire logic [smfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [smfa_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MERGE = 2'd1;
  localparam logic [1:0] ST_DUMP  = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [smfa_pkg::CFG_DATA_W-1:0] row_map_low_r, row_map_high_r;
  smfa_pkg::frame_len_t            frame_length_r;

  logic                    expect_value_r, expect_value_nxt;
  smfa_pkg::nibble_t       held_row_r, held_row_nxt;
  smfa_pkg::nibble_t       held_col_r, held_col_nxt;
  smfa_pkg::frame_len_t    value_count_r, value_count_nxt;
  smfa_pkg::frame_len_t    count_inc;
  logic                    dump_pend_r, dump_pend_nxt;
  smfa_pkg::word_idx_t     waddr_r, waddr_nxt;
  logic [smfa_pkg::BYTE_SEL_W-1:0] byte_sel_r, byte_sel_nxt;
  smfa_pkg::cell_t         wbyte_r, wbyte_nxt;
  smfa_pkg::word_idx_t     dump_idx_r, dump_idx_nxt;
  logic [smfa_pkg::WORD_COUNT-1:0] word_valid_r, word_valid_nxt;

  logic                    out_valid_r, out_valid_nxt;
  smfa_pkg::word_idx_t     out_idx_r;
  smfa_pkg::word_t         out_word_r;
  logic                    out_last_r;
  logic                    out_load;

  logic                    in_fire;
  logic                    ram_we;
  smfa_pkg::word_idx_t     ram_raddr;
  smfa_pkg::word_t         ram_rdata;
  smfa_pkg::word_t         rd_word;
  smfa_pkg::word_t         merged;
  smfa_pkg::word_idx_t     rd_tag_r;

  smfa_ram #(
    .WIDTH(smfa_pkg::WORD_W),
    .DEPTH(smfa_pkg::WORD_COUNT)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr_r),
    .wdata(merged),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign count_inc     = value_count_r + smfa_pkg::frame_len_t'(1);

  // Grid line is (15 - column); word = line * 2 + row bit 3.
  assign waddr_nxt    = in_fire && expect_value_r ? {~held_col_r, held_row_r[3]} : waddr_r;
  assign byte_sel_nxt = in_fire && expect_value_r ? held_row_r[2:0] : byte_sel_r;
  assign wbyte_nxt    = in_fire && expect_value_r ? in_chan.rx_byte : wbyte_r;

  assign ram_raddr = (state_r == ST_DUMP) ? dump_idx_r : waddr_nxt;
  assign ram_we    = (state_r == ST_MERGE);

  // Words never written read as zero.
  assign rd_word = word_valid_r[rd_tag_r] ? ram_rdata : '0;

  always_comb begin
    merged = rd_word;
    for (int b = 0; b < smfa_pkg::WORD_BYTES; b++) begin
      if (byte_sel_r == b[smfa_pkg::BYTE_SEL_W-1:0]) begin
        merged[b*smfa_pkg::CELL_W +: smfa_pkg::CELL_W] = wbyte_r;
      end
    end
  end

  always_comb begin
    state_nxt        = state_r;
    expect_value_nxt = expect_value_r;
    held_row_nxt     = held_row_r;
    held_col_nxt     = held_col_r;
    value_count_nxt  = value_count_r;
    dump_pend_nxt    = dump_pend_r;
    dump_idx_nxt     = dump_idx_r;
    word_valid_nxt   = word_valid_r;
    out_load         = 1'b0;
    out_valid_nxt    = out_valid_r && !out_chan.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!expect_value_r) begin
            held_row_nxt     = smfa_pkg::map_row(in_chan.rx_byte[7:4],
                                                 row_map_low_r, row_map_high_r);
            held_col_nxt     = in_chan.rx_byte[3:0];
            expect_value_nxt = 1'b1;
          end else begin
            expect_value_nxt = 1'b0;
            if (count_inc >= frame_length_r) begin
              value_count_nxt = '0;
              dump_pend_nxt   = 1'b1;
            end else begin
              value_count_nxt = count_inc;
              dump_pend_nxt   = 1'b0;
            end
            state_nxt = ST_MERGE;
          end
        end
      end
      ST_MERGE: begin
        word_valid_nxt[waddr_r] = 1'b1;
        dump_idx_nxt            = '0;
        state_nxt               = dump_pend_r ? ST_DUMP : ST_IDLE;
      end
      ST_DUMP: begin
        // Hold the read until the output register frees up.
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        if (dump_idx_r == smfa_pkg::word_idx_t'(smfa_pkg::WORD_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          dump_idx_nxt = dump_idx_r + smfa_pkg::word_idx_t'(1);
          state_nxt    = ST_DUMP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      expect_value_r <= 1'b0;
      held_row_r     <= '0;
      held_col_r     <= '0;
      value_count_r  <= '0;
      dump_pend_r    <= 1'b0;
      dump_idx_r     <= '0;
      word_valid_r   <= '0;
      out_valid_r    <= 1'b0;
      row_map_low_r  <= smfa_pkg::ROW_MAP_LOW_RST;
      row_map_high_r <= smfa_pkg::ROW_MAP_HIGH_RST;
      frame_length_r <= smfa_pkg::FRAME_LEN_RST;
    end else begin
      state_r        <= state_nxt;
      expect_value_r <= expect_value_nxt;
      held_row_r     <= held_row_nxt;
      held_col_r     <= held_col_nxt;
      value_count_r  <= value_count_nxt;
      dump_pend_r    <= dump_pend_nxt;
      dump_idx_r     <= dump_idx_nxt;
      word_valid_r   <= word_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          smfa_pkg::CFG_ROW_MAP_LOW:  row_map_low_r  <= cfg_wr_data;
          smfa_pkg::CFG_ROW_MAP_HIGH: row_map_high_r <= cfg_wr_data;
          smfa_pkg::CFG_FRAME_LENGTH:
            frame_length_r <= cfg_wr_data[smfa_pkg::FRAME_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    waddr_r    <= waddr_nxt;
    byte_sel_r <= byte_sel_nxt;
    wbyte_r    <= wbyte_nxt;
    rd_tag_r   <= ram_raddr;
    if (out_load) begin
      out_idx_r  <= dump_idx_r;
      out_word_r <= rd_word;
      out_last_r <= (dump_idx_r == smfa_pkg::word_idx_t'(smfa_pkg::WORD_COUNT - 1));
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.word_index = out_idx_r;
  assign out_chan.cell0      = out_word_r[0*smfa_pkg::CELL_W +: smfa_pkg::CELL_W];
  assign out_chan.cell1      = out_word_r[1*smfa_pkg::CELL_W +: smfa_pkg::CELL_W];
  assign out_chan.cell2      = out_word_r[2*smfa_pkg::CELL_W +: smfa_pkg::CELL_W];
  assign out_chan.cell3      = out_word_r[3*smfa_pkg::CELL_W +: smfa_pkg::CELL_W];
  assign out_chan.cell4      = out_word_r[4*smfa_pkg::CELL_W +: smfa_pkg::CELL_W];
  assign out_chan.cell5      = out_word_r[5*smfa_pkg::CELL_W +: smfa_pkg::CELL_W];
  assign out_chan.cell6      = out_word_r[6*smfa_pkg::CELL_W +: smfa_pkg::CELL_W];
  assign out_chan.cell7      = out_word_r[7*smfa_pkg::CELL_W +: smfa_pkg::CELL_W];
  assign out_chan.last_word  = out_last_r;

endmodule
`default_nettype wire

// ===== verif/sensor_matrix_frame_assembler_unit_tb.sv =====
`timescale 1ns / 1ps

module sensor_matrix_frame_assembler_unit_tb;

  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RAND_PHASES   = 8;
  localparam int WIDE_PHASE    = 4;

  localparam logic [smfa_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam smfa_pkg::frame_len_t           FRAME_LEN_MAX = 10'd1023;

  typedef struct packed {
    smfa_pkg::word_idx_t                          word_index;
    smfa_pkg::cell_t [smfa_pkg::WORD_BYTES-1:0]   cells;
    logic                                         last_word;
  } grid_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [smfa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [smfa_pkg::CFG_DATA_W-1:0] cfg_wr_data;

  smfa_in_if  in_if ();
  smfa_out_if out_if ();

  sensor_matrix_frame_assembler_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Grid model and its settings
  smfa_pkg::cell_t                 grid_model [smfa_pkg::CELL_COUNT];
  logic [smfa_pkg::CFG_DATA_W-1:0] map_lo_m;
  logic [smfa_pkg::CFG_DATA_W-1:0] map_hi_m;
  smfa_pkg::frame_len_t            frame_len_m;
  logic                            want_value;
  smfa_pkg::nibble_t               row_hold;
  smfa_pkg::nibble_t               col_hold;
  smfa_pkg::frame_len_t            values_seen;

  grid_word_t      grid_dump_q[$];
  smfa_pkg::cell_t byte_backlog[$];

  int   bytes_queued;
  int   bytes_taken;
  int   words_checked;
  int   dumps_predicted;
  int   settings_used;
  int   errors;
  int   burst_left;
  int   gap_left;
  int   quiet_cycles;
  logic in_fired;
  logic [8:0] stall_phase;

  function automatic smfa_pkg::nibble_t remap_row(input smfa_pkg::nibble_t raw);
    logic [smfa_pkg::CFG_DATA_W-1:0] sel;
    sel = raw[3] ? map_hi_m : map_lo_m;
    return smfa_pkg::nibble_t'(sel >> (raw[2:0] * 4));
  endfunction

  task automatic assemble_byte(input smfa_pkg::cell_t b);
    int unsigned line;
    int unsigned spot;
    grid_word_t  w;
    if (!want_value) begin
      row_hold   = remap_row(b[7:4]);
      col_hold   = b[3:0];
      want_value = 1'b1;
    end else begin
      line = smfa_pkg::GRID_SIDE - 1 - col_hold;
      spot = line * smfa_pkg::GRID_SIDE + row_hold;
      grid_model[spot] = b;
      want_value  = 1'b0;
      values_seen = values_seen + 1'b1;
      // a zero frame length emits after every value
      if (values_seen >= frame_len_m) begin
        values_seen = '0;
        dumps_predicted++;
        for (int i = 0; i < smfa_pkg::WORD_COUNT; i++) begin
          w.word_index = smfa_pkg::word_idx_t'(i);
          for (int c = 0; c < smfa_pkg::WORD_BYTES; c++)
            w.cells[c] = grid_model[i * smfa_pkg::WORD_BYTES + c];
          w.last_word = (i == smfa_pkg::WORD_COUNT - 1);
          grid_dump_q.push_back(w);
        end
      end
    end
  endtask

  task automatic program_reg(input logic [smfa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [smfa_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    case (idx)
      smfa_pkg::CFG_ROW_MAP_LOW:  map_lo_m = data;
      smfa_pkg::CFG_ROW_MAP_HIGH: map_hi_m = data;
      smfa_pkg::CFG_FRAME_LENGTH: frame_len_m = data[smfa_pkg::FRAME_LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_byte(input smfa_pkg::cell_t b);
    byte_backlog.push_back(b);
    bytes_queued++;
  endtask

  // Wait for every byte to be taken and every dump word to arrive, then hold.
  task automatic settle(input int hold);
    while (bytes_taken != bytes_queued || grid_dump_q.size() != 0)
      @(negedge clk);
    repeat (hold) @(negedge clk);
  endtask

  function automatic smfa_pkg::cell_t rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return smfa_pkg::cell_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [smfa_pkg::CFG_DATA_W-1:0] rand_map(
      input logic [smfa_pkg::CFG_DATA_W-1:0] dflt);
    case ($urandom_range(0, 7))
      0, 1:    return dflt;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fired) begin
      if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (byte_backlog.size() > 0) begin
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= byte_backlog.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left <= $urandom_range(30, 80);
          gap_left   <= 0;
        end else begin
          burst_left <= $urandom_range(1, 10);
          gap_left   <= $urandom_range(0, 6);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall mode steps with bits 8:7 of a free-running phase counter
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[8:7])
      2'd0:    out_if.ready <= 1'b1;
      2'd1:    out_if.ready <= (stall_phase[1:0] != 2'b11);
      2'd2:    out_if.ready <= 1'($urandom_range(0, 1));
      default: out_if.ready <= (stall_phase % 5 == 0);
    endcase
  end

  always @(posedge clk) begin : watch_ports
    grid_word_t                                 want;
    smfa_pkg::cell_t [smfa_pkg::WORD_BYTES-1:0] got;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        assemble_byte(in_if.rx_byte);
        bytes_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        got = {out_if.cell7, out_if.cell6, out_if.cell5, out_if.cell4,
               out_if.cell3, out_if.cell2, out_if.cell1, out_if.cell0};
        if (grid_dump_q.size() == 0) begin
          $error("grid word %0d arrived with no dump pending", out_if.word_index);
          errors++;
        end else begin
          want = grid_dump_q.pop_front();
          if (out_if.word_index !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index,
                   out_if.word_index);
            errors++;
          end
          for (int c = 0; c < smfa_pkg::WORD_BYTES; c++) begin
            if (got[c] !== want.cells[c]) begin
              $error("cell%0d: expected %02h, got %02h", c, want.cells[c], got[c]);
              errors++;
            end
          end
          if (out_if.last_word !== want.last_word) begin
            $error("last_word: expected %0b, got %0b", want.last_word,
                   out_if.last_word);
            errors++;
          end
          words_checked++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sensor_matrix_frame_assembler_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int                    n_items;
    smfa_pkg::frame_len_t  frame;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready  = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wr_data   = '0;
    stall_phase   = '0;
    in_fired      = 1'b0;
    map_lo_m      = smfa_pkg::ROW_MAP_LOW_RST;
    map_hi_m      = smfa_pkg::ROW_MAP_HIGH_RST;
    frame_len_m   = smfa_pkg::FRAME_LEN_RST;
    want_value    = 1'b0;
    row_hold      = '0;
    col_hold      = '0;
    values_seen   = '0;
    foreach (grid_model[i]) grid_model[i] = '0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings; end on a header so the next writes land mid-pair
    settings_used = 1;
    queue_byte(8'h00); queue_byte(8'hFF);
    queue_byte(8'hFF); queue_byte(8'h00);
    queue_byte(8'h0F); queue_byte(8'h80);
    queue_byte(8'hF0);
    settle(SETTLE_CYCLES);

    // Zero frame length through masked upper bits; spare index is ignored
    program_reg(smfa_pkg::CFG_FRAME_LENGTH, 32'hFFFF_FC00);
    program_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
    program_reg(smfa_pkg::CFG_ROW_MAP_LOW, 32'h0000_0000);
    program_reg(smfa_pkg::CFG_ROW_MAP_HIGH, 32'hFFFF_FFFF);
    settings_used++;
    queue_byte(8'h7E);
    queue_byte(8'h8C); queue_byte(8'h01);
    queue_byte(8'h3A); queue_byte(8'hC3);
    settle(SETTLE_CYCLES);

    program_reg(smfa_pkg::CFG_FRAME_LENGTH, 32'h0000_0402);
    program_reg(smfa_pkg::CFG_ROW_MAP_LOW, 32'h7654_3210);
    program_reg(smfa_pkg::CFG_ROW_MAP_HIGH, 32'hFEDC_BA98);
    settings_used++;
    queue_byte(8'h5A); queue_byte(8'h55);
    queue_byte(8'hA5); queue_byte(8'hAA);
    queue_byte(8'h33); queue_byte(8'h99);
    settle(SETTLE_CYCLES);

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0)
        frame = 10'd1;
      else if (p == WIDE_PHASE)
        frame = FRAME_LEN_MAX;
      else if (p == RAND_PHASES - 1)
        frame = smfa_pkg::FRAME_LEN_RST;
      else
        frame = smfa_pkg::frame_len_t'($urandom_range(2, 24));
      n_items = $urandom_range(30, 50);
      program_reg(smfa_pkg::CFG_ROW_MAP_LOW, rand_map(smfa_pkg::ROW_MAP_LOW_RST));
      program_reg(smfa_pkg::CFG_ROW_MAP_HIGH, rand_map(smfa_pkg::ROW_MAP_HIGH_RST));
      if ($urandom_range(0, 2) == 0)
        program_reg(CFG_SPARE_IDX, $urandom());
      program_reg(smfa_pkg::CFG_FRAME_LENGTH, {22'($urandom_range(0, 4194303)), frame});
      settings_used++;
      repeat (n_items) queue_byte(rand_byte());
      settle(SETTLE_CYCLES);
    end

    settle(TAIL_CYCLES);
    $display("covered %0d bytes, %0d grid dumps (%0d words checked) over %0d settings",
             bytes_taken, dumps_predicted, words_checked, settings_used);
    $display("frame lengths from zero to %0d, row maps from reset, blank, full and random",
             FRAME_LEN_MAX);
    if (errors == 0 && grid_dump_q.size() == 0)
      $display("sensor_matrix_frame_assembler_unit regression: pass");
    else
      $display("sensor_matrix_frame_assembler_unit regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/smfa_pkg.sv
hdl/smfa_in_if.sv
hdl/smfa_out_if.sv
hdl/smfa_ram.sv
hdl/sensor_matrix_frame_assembler_unit.sv
verif/sensor_matrix_frame_assembler_unit_tb.sv
